// ----- hw/rtl/lfpd_pkg.sv -----
// Package for the length-framed packet deframer.
// Holds register indexes, opcodes, result kinds, limits and the slot config type.
// No dependencies.
package lfpd_pkg;

    localparam int NODE_SLOTS   = 4;
    localparam int LENGTH_LIMIT = 2048;
    localparam int SLOT_COUNT   = (NODE_SLOTS < 4) ? NODE_SLOTS : 4;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_BYTE   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FOOTER_BYTE   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CHECK_BYTE    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BROADCAST_ID  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_NODE_IDS      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_NODE_ENABLE   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT_TICKS = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LENGTH    = 3'd7;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_ACCEPT  = 2'd1;
    localparam logic [1:0] KIND_DROP    = 2'd2;

    localparam logic [11:0] LENGTH_LIMIT_W  = 12'(LENGTH_LIMIT);
    localparam logic [11:0] MIN_LENGTH      = 12'd4;
    localparam logic [7:0]  CHECK_BYTE_RST  = 8'hdd;
    localparam logic [7:0]  BROADCAST_RST   = 8'hff;
    localparam logic [15:0] TIMEOUT_RST     = 16'd300;
    localparam logic [11:0] MAX_LENGTH_RST  = 12'd2048;

    typedef struct packed {
        logic [31:0] node_ids;
        logic [3:0]  node_enable;
        logic [7:0]  broadcast_id;
    } slot_cfg_t;

endpackage

// ----- hw/rtl/lfpd_slot_match.sv -----
// Destination filter: maps a destination byte to the set of node slots it reaches.
// Depends on lfpd_pkg (slot_cfg_t, SLOT_COUNT).
module lfpd_slot_match
(
    input  lfpd_pkg::slot_cfg_t cfg,
    input  logic [7:0]          dest,
    output logic [3:0]          mask
);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mask[i] = (i < lfpd_pkg::SLOT_COUNT) && cfg.node_enable[i] &&
                      ((cfg.node_ids[8*i +: 8] == dest) || (dest == cfg.broadcast_id));
        end
    end

endmodule

// ----- hw/rtl/length_framed_packet_deframer_unit.sv -----
// Length-framed packet deframer, top level.
// A result is registered and appears on m_* in the cycle after its request.
// Throughput: one request per cycle; s_tready drops only while a result is held.
// Reset (rst_n low, async): receiver idle, output empty, config at default values.
// Depends on lfpd_pkg and lfpd_slot_match.
module length_framed_packet_deframer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    // config write port
    input  logic        cfg_wr_en,
    input  logic [lfpd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lfpd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tuser,   // [0] opcode
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [11:8] node_mask, [15:12] zero
    output logic [1:0]  m_tuser    // [1:0] kind
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_LEN_LO = 3'd1;
    localparam logic [2:0] PH_LEN_HI = 3'd2;
    localparam logic [2:0] PH_DEST   = 3'd3;
    localparam logic [2:0] PH_BODY   = 3'd4;
    localparam logic [2:0] PH_FOOTER = 3'd5;
    localparam logic [2:0] PH_CHECK  = 3'd6;

    // config registers
    logic [7:0]  header_byte_reg;
    logic [7:0]  footer_byte_reg;
    logic [7:0]  check_byte_reg;
    logic [7:0]  broadcast_id_reg;
    logic [31:0] node_ids_reg;
    logic [3:0]  node_enable_reg;
    logic [15:0] timeout_ticks_reg;
    logic [11:0] max_length_reg;

    // frame state
    logic [2:0]  phase_reg,      phase_next;
    logic [7:0]  len_lo_reg,     len_lo_next;
    logic [11:0] frame_len_reg,  frame_len_next;
    logic [11:0] byte_idx_reg,   byte_idx_next;
    logic        footer_ok_reg,  footer_ok_next;
    logic [3:0]  match_mask_reg, match_mask_next;
    logic [15:0] tick_cnt_reg,   tick_cnt_next;
    logic        timer_run_reg,  timer_run_next;

    // output register
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg,   out_kind_next;
    logic [7:0]  out_byte_reg,   out_byte_next;
    logic [3:0]  out_mask_reg;
    logic        emit;

    logic        s_accept;
    logic [15:0] len_full;
    logic [11:0] len_lim;
    logic [11:0] idx_inc;
    logic [15:0] tick_inc;
    logic [3:0]  dest_mask;
    lfpd_pkg::slot_cfg_t slot_cfg;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign slot_cfg.node_ids     = node_ids_reg;
    assign slot_cfg.node_enable  = node_enable_reg;
    assign slot_cfg.broadcast_id = broadcast_id_reg;

    lfpd_slot_match u_slot_match
    (
        .cfg  (slot_cfg),
        .dest (s_tdata),
        .mask (dest_mask)
    );

    assign len_full = {s_tdata, len_lo_reg};
    assign len_lim  = (max_length_reg < lfpd_pkg::LENGTH_LIMIT_W) ? max_length_reg
                                                                  : lfpd_pkg::LENGTH_LIMIT_W;
    assign idx_inc  = byte_idx_reg + 12'd1;
    assign tick_inc = tick_cnt_reg + 16'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        len_lo_next     = len_lo_reg;
        frame_len_next  = frame_len_reg;
        byte_idx_next   = byte_idx_reg;
        footer_ok_next  = footer_ok_reg;
        match_mask_next = match_mask_reg;
        tick_cnt_next   = tick_cnt_reg;
        timer_run_next  = timer_run_reg;
        emit            = 1'b0;
        out_kind_next   = lfpd_pkg::KIND_PAYLOAD;
        out_byte_next   = 8'd0;

        if (s_tuser == lfpd_pkg::OP_TICK)
        begin
            if (timer_run_reg && (phase_reg != PH_IDLE))
            begin
                tick_cnt_next = tick_inc;
                if ((tick_inc >= timeout_ticks_reg) || (tick_inc == 16'd0))
                begin
                    phase_next     = PH_IDLE;
                    timer_run_next = 1'b0;
                    tick_cnt_next  = 16'd0;
                    if (phase_reg >= PH_BODY)
                    begin
                        emit          = 1'b1;
                        out_kind_next = lfpd_pkg::KIND_DROP;
                    end
                end
            end
        end
        else
        begin
            if (phase_reg != PH_IDLE)
            begin
                tick_cnt_next = 16'd0;
            end
            case (phase_reg)
                PH_IDLE:
                begin
                    if (s_tdata == header_byte_reg)
                    begin
                        phase_next      = PH_LEN_LO;
                        tick_cnt_next   = 16'd0;
                        timer_run_next  = 1'b1;
                        match_mask_next = 4'd0;
                        footer_ok_next  = 1'b0;
                        byte_idx_next   = 12'd0;
                    end
                end
                PH_LEN_LO:
                begin
                    len_lo_next = s_tdata;
                    phase_next  = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    if ((len_full > {4'd0, len_lim}) || (len_full < {4'd0, lfpd_pkg::MIN_LENGTH}))
                    begin
                        phase_next     = PH_IDLE;
                        timer_run_next = 1'b0;
                        tick_cnt_next  = 16'd0;
                    end
                    else
                    begin
                        frame_len_next = len_full[11:0];
                        byte_idx_next  = 12'd0;
                        phase_next     = PH_DEST;
                    end
                end
                PH_DEST:
                begin
                    match_mask_next = dest_mask;
                    phase_next      = PH_BODY;
                end
                PH_BODY:
                begin
                    byte_idx_next = idx_inc;
                    if (idx_inc >= (frame_len_reg - 12'd3))
                    begin
                        phase_next = PH_FOOTER;
                    end
                    emit          = 1'b1;
                    out_kind_next = lfpd_pkg::KIND_PAYLOAD;
                    out_byte_next = s_tdata;
                end
                PH_FOOTER:
                begin
                    footer_ok_next = (s_tdata == footer_byte_reg);
                    phase_next     = PH_CHECK;
                end
                PH_CHECK:
                begin
                    phase_next     = PH_IDLE;
                    timer_run_next = 1'b0;
                    tick_cnt_next  = 16'd0;
                    emit           = 1'b1;
                    out_kind_next  = (footer_ok_reg && (s_tdata == check_byte_reg))
                                     ? lfpd_pkg::KIND_ACCEPT : lfpd_pkg::KIND_DROP;
                end
                default:
                begin
                    phase_next     = PH_IDLE;
                    timer_run_next = 1'b0;
                    tick_cnt_next  = 16'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_byte_reg   <= 8'd0;
            footer_byte_reg   <= 8'd0;
            check_byte_reg    <= lfpd_pkg::CHECK_BYTE_RST;
            broadcast_id_reg  <= lfpd_pkg::BROADCAST_RST;
            node_ids_reg      <= 32'd0;
            node_enable_reg   <= 4'd0;
            timeout_ticks_reg <= lfpd_pkg::TIMEOUT_RST;
            max_length_reg    <= lfpd_pkg::MAX_LENGTH_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                lfpd_pkg::REG_HEADER_BYTE:   header_byte_reg   <= cfg_wdata[7:0];
                lfpd_pkg::REG_FOOTER_BYTE:   footer_byte_reg   <= cfg_wdata[7:0];
                lfpd_pkg::REG_CHECK_BYTE:    check_byte_reg    <= cfg_wdata[7:0];
                lfpd_pkg::REG_BROADCAST_ID:  broadcast_id_reg  <= cfg_wdata[7:0];
                lfpd_pkg::REG_NODE_IDS:      node_ids_reg      <= cfg_wdata;
                lfpd_pkg::REG_NODE_ENABLE:   node_enable_reg   <= cfg_wdata[3:0];
                lfpd_pkg::REG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata[15:0];
                lfpd_pkg::REG_MAX_LENGTH:    max_length_reg    <= cfg_wdata[11:0];
                default:                     header_byte_reg   <= header_byte_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            len_lo_reg     <= 8'd0;
            frame_len_reg  <= 12'd0;
            byte_idx_reg   <= 12'd0;
            footer_ok_reg  <= 1'b0;
            match_mask_reg <= 4'd0;
            tick_cnt_reg   <= 16'd0;
            timer_run_reg  <= 1'b0;
        end
        else if (s_accept)
        begin
            phase_reg      <= phase_next;
            len_lo_reg     <= len_lo_next;
            frame_len_reg  <= frame_len_next;
            byte_idx_reg   <= byte_idx_next;
            footer_ok_reg  <= footer_ok_next;
            match_mask_reg <= match_mask_next;
            tick_cnt_reg   <= tick_cnt_next;
            timer_run_reg  <= timer_run_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            out_valid_reg <= emit;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload; mask is the frame's mask before this request updates it
    always_ff @(posedge clk)
    begin
        if (s_accept && emit)
        begin
            out_kind_reg <= out_kind_next;
            out_byte_reg <= out_byte_next;
            out_mask_reg <= match_mask_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {4'd0, out_mask_reg, out_byte_reg};

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output register");

    a_timer_tracks_phase: assert property (@(posedge clk) disable iff (!rst_n)
        timer_run_reg == (phase_reg != PH_IDLE))
        else $error("timer state disagrees with frame phase");

    a_body_byte_emits: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept && (s_tuser == lfpd_pkg::OP_BYTE) && (phase_reg == PH_BODY)
        |=> m_tvalid && (m_tuser == lfpd_pkg::KIND_PAYLOAD))
        else $error("body byte did not produce a payload result");

    a_end_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != lfpd_pkg::KIND_PAYLOAD) |-> (m_tdata[7:0] == 8'd0))
        else $error("frame end result carries nonzero byte");

endmodule

// ----- tb/length_framed_packet_deframer_unit_tb.sv -----
// Self-checking testbench for length_framed_packet_deframer_unit.
// Predicts every payload, accept and drop result from a behavioral model of the
// receiver. Depends on lfpd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module length_framed_packet_deframer_unit_tb;

    localparam int HOLD_CYCLES = 300;

    typedef enum logic [2:0] {
        RX_IDLE,
        RX_LEN_LO,
        RX_LEN_HI,
        RX_DEST,
        RX_BODY,
        RX_FOOTER,
        RX_CHECK
    } rx_phase_e;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } rx_request_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [3:0] node_mask;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [lfpd_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [lfpd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;    // [7:0] rx_byte
    logic        s_tuser = 1'b0;  // [0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [7:0] out_byte, [11:8] node_mask, [15:12] zero
    logic [1:0]  m_tuser;         // [1:0] kind

    // register copies
    logic [7:0]  cfg_header = '0;
    logic [7:0]  cfg_footer = '0;
    logic [7:0]  cfg_check = lfpd_pkg::CHECK_BYTE_RST;
    logic [7:0]  cfg_broadcast = lfpd_pkg::BROADCAST_RST;
    logic [31:0] cfg_node_ids = '0;
    logic [3:0]  cfg_enable = '0;
    logic [15:0] cfg_timeout = lfpd_pkg::TIMEOUT_RST;
    logic [11:0] cfg_max_len = lfpd_pkg::MAX_LENGTH_RST;

    // receiver state copy
    rx_phase_e   rx_phase = RX_IDLE;
    logic [7:0]  len_low = '0;
    logic [11:0] frame_len = '0;
    logic [11:0] body_count = '0;
    logic        footer_ok_seen = 1'b0;
    logic [3:0]  frame_mask = '0;
    logic [15:0] idle_ticks = '0;
    logic        timer_on = 1'b0;

    rx_request_t   pending_requests[$];
    frame_result_t frame_results[$];
    rx_request_t   next_request;
    frame_result_t result_due;

    int requests_queued = 0;
    int requests_accepted = 0;
    int mismatches = 0;
    int send_idle_pct = 0;
    int ready_stall_pct = 0;
    bit hold_arm = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    length_framed_packet_deframer_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int length_cap();
        return (cfg_max_len < lfpd_pkg::LENGTH_LIMIT) ? int'(cfg_max_len)
                                                      : lfpd_pkg::LENGTH_LIMIT;
    endfunction

    function automatic logic [3:0] slots_for_dest(logic [7:0] dest);
        logic [3:0] mask;
        mask = '0;
        for (int i = 0; i < lfpd_pkg::SLOT_COUNT; i++)
            if (cfg_enable[i] && (cfg_node_ids[8*i +: 8] == dest || dest == cfg_broadcast))
                mask[i] = 1'b1;
        return mask;
    endfunction

    function automatic void close_frame();
        rx_phase = RX_IDLE;
        timer_on = 1'b0;
        idle_ticks = '0;
    endfunction

    function automatic void push_result(logic [1:0] kind, logic [7:0] b);
        frame_results.push_back('{kind, b, frame_mask});
    endfunction

    function automatic void predict_request(logic op, logic [7:0] b);
        logic [15:0] len;
        bit streamed;
        if (op == lfpd_pkg::OP_TICK)
        begin
            if (timer_on && rx_phase != RX_IDLE)
            begin
                idle_ticks = idle_ticks + 16'd1;
                if (idle_ticks >= cfg_timeout || idle_ticks == 16'd0)
                begin
                    streamed = (rx_phase >= RX_BODY);
                    close_frame();
                    if (streamed)
                        push_result(lfpd_pkg::KIND_DROP, 8'd0);
                end
            end
            return;
        end
        if (rx_phase != RX_IDLE)
            idle_ticks = '0;
        case (rx_phase)
            RX_IDLE:
                if (b == cfg_header)
                begin
                    rx_phase = RX_LEN_LO;
                    idle_ticks = '0;
                    timer_on = 1'b1;
                    frame_mask = '0;
                    footer_ok_seen = 1'b0;
                    body_count = '0;
                end
            RX_LEN_LO:
            begin
                len_low = b;
                rx_phase = RX_LEN_HI;
            end
            RX_LEN_HI:
            begin
                len = {b, len_low};
                if (len > length_cap() || len < 16'(lfpd_pkg::MIN_LENGTH))
                    close_frame();
                else
                begin
                    frame_len = len[11:0];
                    body_count = '0;
                    rx_phase = RX_DEST;
                end
            end
            RX_DEST:
            begin
                frame_mask = slots_for_dest(b);
                rx_phase = RX_BODY;
            end
            RX_BODY:
            begin
                body_count = body_count + 12'd1;
                if (body_count >= frame_len - 12'd3)
                    rx_phase = RX_FOOTER;
                push_result(lfpd_pkg::KIND_PAYLOAD, b);
            end
            RX_FOOTER:
            begin
                footer_ok_seen = (b == cfg_footer);
                rx_phase = RX_CHECK;
            end
            RX_CHECK:
            begin
                close_frame();
                push_result((footer_ok_seen && b == cfg_check) ? lfpd_pkg::KIND_ACCEPT
                                                               : lfpd_pkg::KIND_DROP, 8'd0);
            end
            default:
                close_frame();
        endcase
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= lfpd_pkg::OP_BYTE;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_request(s_tuser, s_tdata);
                requests_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_request = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_request.op;
                    s_tdata  <= next_request.rx_byte;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result ready, with a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_seen <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_arm != hold_seen)
        begin
            hold_seen <= hold_arm;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frame_results.size() == 0)
            begin
                $error("unexpected result: kind %0d out_byte %02h node_mask %01h",
                       m_tuser, m_tdata[7:0], m_tdata[11:8]);
                mismatches++;
            end
            else
            begin
                result_due = frame_results.pop_front();
                if (m_tuser !== result_due.kind)
                begin
                    $error("kind: expected %0d, actual %0d", result_due.kind, m_tuser);
                    mismatches++;
                end
                if (m_tdata[7:0] !== result_due.out_byte)
                begin
                    $error("out_byte: expected %02h, actual %02h",
                           result_due.out_byte, m_tdata[7:0]);
                    mismatches++;
                end
                if (m_tdata[11:8] !== result_due.node_mask)
                begin
                    $error("node_mask: expected %01h, actual %01h",
                           result_due.node_mask, m_tdata[11:8]);
                    mismatches++;
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            lfpd_pkg::REG_HEADER_BYTE:   cfg_header = val[7:0];
            lfpd_pkg::REG_FOOTER_BYTE:   cfg_footer = val[7:0];
            lfpd_pkg::REG_CHECK_BYTE:    cfg_check = val[7:0];
            lfpd_pkg::REG_BROADCAST_ID:  cfg_broadcast = val[7:0];
            lfpd_pkg::REG_NODE_IDS:      cfg_node_ids = val;
            lfpd_pkg::REG_NODE_ENABLE:   cfg_enable = val[3:0];
            lfpd_pkg::REG_TIMEOUT_TICKS: cfg_timeout = val[15:0];
            lfpd_pkg::REG_MAX_LENGTH:    cfg_max_len = val[11:0];
            default:                     ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(logic [7:0] header, logic [7:0] footer, logic [7:0] check,
                              logic [7:0] bcast, logic [31:0] ids, logic [3:0] enable,
                              logic [15:0] timeout, logic [11:0] max_len);
        write_reg(lfpd_pkg::REG_HEADER_BYTE, 32'(header));
        write_reg(lfpd_pkg::REG_FOOTER_BYTE, 32'(footer));
        write_reg(lfpd_pkg::REG_CHECK_BYTE, 32'(check));
        write_reg(lfpd_pkg::REG_BROADCAST_ID, 32'(bcast));
        write_reg(lfpd_pkg::REG_NODE_IDS, ids);
        write_reg(lfpd_pkg::REG_NODE_ENABLE, 32'(enable));
        write_reg(lfpd_pkg::REG_TIMEOUT_TICKS, 32'(timeout));
        write_reg(lfpd_pkg::REG_MAX_LENGTH, 32'(max_len));
    endtask

    task automatic queue_request(logic op, logic [7:0] b);
        pending_requests.push_back('{op, b});
        requests_queued++;
    endtask

    task automatic queue_ticks(int n);
        for (int k = 0; k < n; k++)
            queue_request(lfpd_pkg::OP_TICK, 8'($urandom));
    endtask

    task automatic queue_header(int len);
        queue_request(lfpd_pkg::OP_BYTE, cfg_header);
        queue_request(lfpd_pkg::OP_BYTE, 8'(len));
        queue_request(lfpd_pkg::OP_BYTE, 8'(len >> 8));
    endtask

    task automatic queue_frame(int len, logic [7:0] dest, int body, bit footer_ok,
                               bit check_ok, int tick_max, bit closed);
        queue_header(len);
        queue_request(lfpd_pkg::OP_BYTE, dest);
        for (int k = 0; k < body; k++)
        begin
            if (tick_max > 0 && $urandom_range(7) == 0)
                queue_ticks($urandom_range(1, tick_max));
            queue_request(lfpd_pkg::OP_BYTE,
                          ($urandom_range(7) == 0) ? cfg_header : 8'($urandom));
        end
        if (closed)
        begin
            queue_request(lfpd_pkg::OP_BYTE,
                          footer_ok ? cfg_footer : cfg_footer ^ 8'($urandom_range(1, 255)));
            queue_request(lfpd_pkg::OP_BYTE,
                          check_ok ? cfg_check : cfg_check ^ 8'($urandom_range(1, 255)));
        end
    endtask

    function automatic int pick_length();
        int cap;
        cap = length_cap();
        if (cap < 4)
            return $urandom_range(8);
        if ($urandom_range(19) == 0)
            return (cap > 64) ? 4 + $urandom_range(60) : cap;
        return 4 + $urandom_range((cap - 4 > 12) ? 12 : cap - 4);
    endfunction

    function automatic logic [7:0] pick_dest();
        int r;
        r = $urandom_range(9);
        if (r < 4)
            return cfg_node_ids[8*r +: 8];
        if (r < 6)
            return cfg_broadcast;
        return 8'($urandom);
    endfunction

    task automatic queue_random_traffic(int count);
        int stop_at;
        int sel;
        int len;
        int body_len;
        int run_max;
        int abort_ticks;
        int cut;
        logic [7:0] dest;
        logic [7:0] noise;
        stop_at = requests_queued + count;
        while (requests_queued < stop_at)
        begin
            sel = $urandom_range(99);
            len = pick_length();
            body_len = (len > 3) ? len - 3 : 1;
            dest = pick_dest();
            run_max = (cfg_timeout > 16'd7) ? 6 : ((cfg_timeout > 16'd1) ? cfg_timeout - 1 : 0);
            abort_ticks = (cfg_timeout == 16'd0) ? 1 : ((cfg_timeout > 16'd20) ? 20 : cfg_timeout);
            if (sel < 70)
                queue_frame(len, dest, body_len, 1'b1, 1'b1, run_max, 1'b1);
            else if (sel < 76)
                queue_frame(len, dest, body_len, 1'b0, 1'($urandom_range(1)), run_max, 1'b1);
            else if (sel < 80)
                queue_frame(len, dest, body_len, 1'b1, 1'b0, run_max, 1'b1);
            else if (sel < 86)
            begin
                // length out of range, or a random length in the last case
                case ($urandom_range(3))
                    0:       len = $urandom_range(3);
                    1:       len = length_cap() + 1 + $urandom_range(8);
                    2:       len = 16'hFFFF;
                    default: len = $urandom_range(16'hFFFF);
                endcase
                queue_frame(len, dest, $urandom_range(4), 1'b1, 1'b1, 0, 1'b0);
            end
            else if (sel < 92)
            begin
                // frame cut short, then given ticks toward a timeout, at most 20
                cut = $urandom_range(3);
                if (cut == 3)
                    queue_frame(len, dest, $urandom_range(body_len), 1'b1, 1'b1, 0, 1'b0);
                else
                begin
                    queue_request(lfpd_pkg::OP_BYTE, cfg_header);
                    if (cut > 0)
                        queue_request(lfpd_pkg::OP_BYTE, 8'(len));
                    if (cut > 1)
                        queue_request(lfpd_pkg::OP_BYTE, 8'(len >> 8));
                end
                queue_ticks(abort_ticks);
            end
            else if (sel < 96)
            begin
                for (int k = $urandom_range(1, 4); k > 0; k--)
                begin
                    noise = 8'($urandom);
                    if (noise == cfg_header)
                        noise = ~noise;
                    if ($urandom_range(1))
                        queue_request(lfpd_pkg::OP_TICK, noise);
                    else
                        queue_request(lfpd_pkg::OP_BYTE, noise);
                end
            end
            else
                queue_frame(len, dest, body_len, 1'b1, 1'b1, abort_ticks + 1, 1'b1);
        end
    endtask

    task automatic drain();
        while (requests_accepted != requests_queued || frame_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed frames
        set_config(8'hA5, 8'h5A, 8'hC3, 8'hFF, 32'h4433_2211, 4'b1011, 16'd2, 12'd2048);
        queue_request(lfpd_pkg::OP_TICK, 8'hFF);
        queue_frame(4, 8'h22, 1, 1'b1, 1'b1, 0, 1'b1);
        queue_header(16'hFFFF);
        queue_header(3);
        queue_frame(5, 8'hFF, 2, 1'b0, 1'b1, 0, 1'b1);
        queue_header(4);
        queue_request(lfpd_pkg::OP_BYTE, 8'h33);
        queue_request(lfpd_pkg::OP_BYTE, 8'hA5);
        queue_ticks(2);
        queue_header(4);
        queue_ticks(2);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: set_config(8'h00, 8'hFF, 8'h00, 8'h00, 32'hFFFF_FFFF, 4'h0, 16'd1, 12'd4);
                1: set_config(8'hFF, 8'h00, 8'hFF, 8'hFF, $urandom, 4'hF, 16'hFFFF, 12'hFFF);
                2: set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                              $urandom, 4'($urandom), 16'd0, 12'd3);
                default:
                begin
                    set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                               $urandom, 4'($urandom), 16'($urandom_range(1, 8)),
                               12'($urandom_range(4, 48)));
                    if ($urandom_range(1))
                        write_reg(lfpd_pkg::REG_NODE_IDS, {cfg_node_ids[31:24], cfg_node_ids[7:0],
                                                           cfg_node_ids[15:0]});
                end
            endcase
            case (p % 4)
                0:       begin send_idle_pct = 0;  ready_stall_pct = 0;  end
                1:       begin send_idle_pct = 49; ready_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  ready_stall_pct = 49; end
                default: begin send_idle_pct = 11; ready_stall_pct = 11; end
            endcase
            if (p == 3)
            begin
                send_idle_pct = 0;
                ready_stall_pct = 0;
                hold_arm <= ~hold_arm;
            end
            queue_random_traffic((p == 2) ? 60 : 120);
            if (p == 1)
            begin
                // largest legal length opens a frame, cut short and timed out
                drain();
                write_reg(lfpd_pkg::REG_TIMEOUT_TICKS, 32'd4);
                queue_frame(2048, pick_dest(), 3, 1'b1, 1'b1, 0, 1'b0);
                queue_ticks(4);
                queue_frame(2049, pick_dest(), 2, 1'b1, 1'b1, 0, 1'b0);
            end
            drain();
        end

        if (mismatches == 0 && frame_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/lfpd_pkg.sv
hw/rtl/lfpd_slot_match.sv
hw/rtl/length_framed_packet_deframer_unit.sv
tb/length_framed_packet_deframer_unit_tb.sv
